/* hdl/tts_pkg.sv */
// Shared constants and types for the tick task scheduler.
// No dependencies.
package tts_pkg;
	localparam int MAX_TASKS = 16;
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int PAR_W = 16 + 16 + 16 + 5 + 8;
	localparam int DYN_W = 17 + 32 + 32;
	localparam logic [16:0] WORK_MAX = 17'h1FFFF;
	localparam logic [4:0] RUNNER_NONE = 5'd31;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] MODE_FP = 2'd0;
	localparam logic [1:0] MODE_EDF = 2'd1;
	localparam logic [1:0] MODE_LST = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic [15:0] period;
		logic [15:0] deadline;
		logic [15:0] wcet;
		logic [4:0]  prio;
		logic [7:0]  label;
	} task_par_t;

	typedef struct packed {
		logic [16:0] work;
		logic [31:0] rel;
		logic [31:0] due;
	} task_dyn_t;
endpackage

/* hdl/tick_task_scheduler_core.sv */
// Tick task scheduler: one item at a time, sweeping the task memories.
// Depends on tts_pkg and tts_ram.
//
// Use: input items arrive on valid/stall (opcode plus entry fields).
// A load writes one task parameter entry; the next item can be taken in the
// following cycle. A restart clears the runtime memory slot by slot in
// ST_CLR and then returns to idle for the next item. A tick scans the n
// slots in use (n at most MAX_TASKS), one memory read per cycle, releasing
// and ranking each, then reads, decrements and writes back the runner.
// Its result is loaded into the output register from ST_OUT, and the next
// item can be taken once the scheduler is back in ST_IDLE.
// One result item per tick on the output channel (valid/stall), held in an
// output register; the next input item is taken while a result waits, but
// the following result waits for it.
// After reset the runtime memory is cleared by a pass over all MAX_TASKS slots
// during which no item is accepted; configuration writes are always taken.
// Task parameter entries are undefined until loaded.
// Configuration via an APB-style port: sched_mode at 0x0, task_count at 0x4.
module tick_task_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        stall_in,
	input  logic [1:0]  opcode,
	input  logic [3:0]  entry_index,
	input  logic [15:0] entry_period,
	input  logic [15:0] entry_deadline,
	input  logic [15:0] entry_wcet,
	input  logic [4:0]  entry_priority,
	input  logic [7:0]  entry_label,
	output logic        valid_out,
	input  logic        stall_out,
	output logic [31:0] tick_time,
	output logic [3:0]  running_index,
	output logic [7:0]  running_label,
	output logic        idle,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_RD = 3'd3;
	localparam logic [2:0] ST_WR = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	localparam int IW = tts_pkg::IDX_W;
	localparam int CW = tts_pkg::CNT_W;

	logic [2:0] state_q;
	logic [1:0] mode_q;
	logic [4:0] count_q;
	logic [31:0] now_q;
	logic [4:0] last_q;
	logic [CW-1:0] ptr_q;     // issue pointer
	logic [CW-1:0] n_lim;
	logic rv_s1;              // read data valid next cycle
	logic [IW-1:0] ra_s1;
	logic have_q;
	logic [IW-1:0] best_q;
	logic [4:0] bpri_q;
	logic signed [33:0] bkey_q;

	tts_pkg::task_par_t par_w, par_r;
	tts_pkg::task_dyn_t dyn_w, dyn_r, dyn_n;
	logic par_we, dyn_we;
	logic [IW-1:0] par_ra, dyn_ra, dyn_wa;

	logic acc_in, cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		case (paddr[2])
			tts_pkg::REG_MODE: prdata[1:0] = mode_q;
			tts_pkg::REG_COUNT: prdata[4:0] = count_q;
			default: prdata = '0;
		endcase
	end

	assign stall_in = (state_q != ST_IDLE);
	assign acc_in = valid_in && !stall_in;
	assign n_lim = (count_q > 5'(tts_pkg::MAX_TASKS)) ? CW'(tts_pkg::MAX_TASKS)
		: CW'(count_q);

	assign par_w = '{entry_period, entry_deadline, entry_wcet, entry_priority, entry_label};
	assign par_we = acc_in && (opcode == tts_pkg::OP_LOAD);

	tts_ram #(.WIDTH(tts_pkg::PAR_W), .DEPTH(tts_pkg::MAX_TASKS)) u_par (
		.clk(clk), .we(par_we), .waddr(entry_index[IW-1:0]), .wdata(par_w),
		.raddr(par_ra), .rdata(par_r)
	);
	tts_ram #(.WIDTH(tts_pkg::DYN_W), .DEPTH(tts_pkg::MAX_TASKS)) u_dyn (
		.clk(clk), .we(dyn_we), .waddr(dyn_wa), .wdata(dyn_w),
		.raddr(dyn_ra), .rdata(dyn_r)
	);

	// release applied to a scanned slot
	logic [17:0] wsum;
	logic signed [33:0] key;
	logic better;
	always_comb begin
		dyn_n = dyn_r;
		wsum = {1'b0, dyn_r.work} + {2'b0, par_r.wcet};
		if (dyn_r.rel == now_q) begin
			dyn_n.work = wsum[17] ? tts_pkg::WORK_MAX : wsum[16:0];
			dyn_n.due = dyn_r.rel + 32'(par_r.deadline);
			dyn_n.rel = dyn_r.rel + 32'(par_r.period);
		end
		key = 34'(signed'(dyn_n.due - now_q));
		if (mode_q == tts_pkg::MODE_LST) key = key - 34'(dyn_n.work);
		better = 1'b0;
		if (dyn_n.work != '0) begin
			if (mode_q == tts_pkg::MODE_EDF || mode_q == tts_pkg::MODE_LST) begin
				better = !have_q || key < bkey_q
					|| (key == bkey_q && 5'(ra_s1) == last_q);
			end else begin
				better = par_r.prio > bpri_q;
			end
		end
	end

	always_comb begin
		dyn_ra = ptr_q[IW-1:0];
		par_ra = ptr_q[IW-1:0];
		// runner entry stays addressed until its result has gone out
		if (state_q == ST_RD || state_q == ST_WR || state_q == ST_OUT) begin
			dyn_ra = best_q;
			par_ra = best_q;
		end
		dyn_we = 1'b0;
		dyn_wa = ra_s1;
		dyn_w = dyn_n;
		if (state_q == ST_CLR) begin
			dyn_we = 1'b1;
			dyn_wa = ptr_q[IW-1:0];
			dyn_w = '0;
		end else if (state_q == ST_SCAN && rv_s1) begin
			dyn_we = 1'b1;
		end else if (state_q == ST_WR && have_q) begin
			dyn_we = 1'b1;
			dyn_wa = best_q;
			dyn_w = dyn_r;
			dyn_w.work = dyn_r.work - 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			mode_q <= '0;
			count_q <= '0;
			now_q <= '0;
			last_q <= tts_pkg::RUNNER_NONE;
			ptr_q <= '0;
			rv_s1 <= 1'b0;
			ra_s1 <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			bpri_q <= '0;
			bkey_q <= '0;
			valid_out <= 1'b0;
			tick_time <= '0;
			running_index <= '0;
			running_label <= '0;
			idle <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					tts_pkg::REG_MODE: mode_q <= pwdata[1:0];
					tts_pkg::REG_COUNT: count_q <= pwdata[4:0];
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!valid_out || !stall_out)) begin
				valid_out <= 1'b1;
			end else if (!stall_out) begin
				valid_out <= 1'b0;
			end
			rv_s1 <= (state_q == ST_SCAN) && (ptr_q < n_lim);
			case (state_q)
				ST_CLR: begin
					if (ptr_q == CW'(tts_pkg::MAX_TASKS - 1)) begin
						state_q <= ST_IDLE;
						ptr_q <= '0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (acc_in) begin
						if (opcode == tts_pkg::OP_RESTART) begin
							state_q <= ST_CLR;
							now_q <= '0;
							last_q <= tts_pkg::RUNNER_NONE;
						end else if (opcode == tts_pkg::OP_TICK) begin
							state_q <= ST_SCAN;
							have_q <= 1'b0;
							bpri_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (ptr_q < n_lim) begin
						ra_s1 <= ptr_q[IW-1:0];
						ptr_q <= ptr_q + 1'b1;
					end else if (!rv_s1) begin
						state_q <= ST_RD;
						ptr_q <= '0;
					end
					if (rv_s1 && better) begin
						have_q <= 1'b1;
						best_q <= ra_s1;
						bkey_q <= key;
						bpri_q <= par_r.prio;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: state_q <= ST_OUT;
				ST_OUT: begin
					if (!valid_out || !stall_out) begin
						tick_time <= now_q;
						running_index <= have_q ? 4'(best_q) : 4'd0;
						running_label <= have_q ? par_r.label : 8'd0;
						idle <= !have_q;
						if (have_q) last_q <= 5'(best_q);
						now_q <= now_q + 32'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stable_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && stall_out |=> valid_out && $stable(tick_time))
		else $error("result changed while stalled");
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && idle |-> running_index == 4'd0 && running_label == 8'd0)
		else $error("idle result with runner");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> stall_in)
		else $error("item accepted during scan");
`endif
endmodule

/* hdl/tts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
